// ===== rtl/mtem_pkg.sv =====
package mtem_pkg;

  localparam int HIST_DEPTH = 128;
  localparam int TAP_COUNT  = 8;

  localparam int SAMPLE_W   = 8;
  localparam int DELAY_W    = 7;
  localparam int WEIGHT_W   = 10;
  localparam int REG_W      = DELAY_W + WEIGHT_W;

  localparam int HIST_IDX_W = $clog2(HIST_DEPTH);
  localparam int FILL_W     = $clog2(HIST_DEPTH + 1);
  localparam int TAP_IDX_W  = $clog2(TAP_COUNT);
  localparam int TAP_CNT_W  = $clog2(TAP_COUNT + 1);

  // cell row is read back through registered groups of this size
  localparam int GROUP_SIZE = 16;
  localparam int NUM_GROUPS = HIST_DEPTH / GROUP_SIZE;

  localparam int PROD_W     = WEIGHT_W + SAMPLE_W;
  localparam int TERM_W     = PROD_W - 8;
  // dry term max 84 plus TAP_COUNT terms of at most 1019
  localparam int ACC_W      = 14;

  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(128);
  localparam logic [ACC_W-1:0]  SAT_MAX    = ACC_W'(255);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_FLUSH,
    ST_DONE
  } state_t;

  typedef logic [NUM_GROUPS-1:0][SAMPLE_W-1:0] grp_t;

  typedef struct packed {
    logic load;
    logic vld;
  } mac_ctl_t;

  typedef struct packed {
    logic busy;
  } mac_sts_t;

  function automatic logic [HIST_IDX_W-1:0] tap_delay(input logic [REG_W-1:0] tap_reg);
    logic [DELAY_W-1:0] d;
    d = tap_reg[DELAY_W-1:0];
    if (int'(d) > HIST_DEPTH - 1) begin
      return HIST_IDX_W'(HIST_DEPTH - 1);
    end else begin
      return HIST_IDX_W'(d);
    end
  endfunction

  function automatic logic [WEIGHT_W-1:0] tap_weight(input logic [REG_W-1:0] tap_reg);
    return tap_reg[REG_W-1:DELAY_W];
  endfunction

  // round(0.33 * x) half up: (33x + 50) / 100 via reciprocal 5243 / 2^19
  function automatic logic [SAMPLE_W-1:0] dry_gain(input logic [SAMPLE_W-1:0] x);
    logic [13:0] v;
    logic [26:0] p;
    v = 14'(x) * 14'd33 + 14'd50;
    p = 27'(v) * 27'd5243;
    return p[26:19];
  endfunction

endpackage

// ===== rtl/multi_tap_echo_mixer.sv =====
// an input transaction goes straight to the result register while warming up or with no taps;
//   with active taps the result is loaded after the tap walk and the accumulator flush
// a new item is taken only after the previous result has been loaded into the output register;
//   one tap per cycle is read from the cell row and fed to the shared multiply-accumulate
// reset: synchronous, active low; clears tap registers, history cells and fill count
module multi_tap_echo_mixer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mtem_pkg::SAMPLE_W-1:0]  in_sample_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mtem_pkg::SAMPLE_W-1:0]  out_sample_out,
  output logic                          out_warming_up,
  input  logic                          cfg_we,
  input  logic [mtem_pkg::TAP_IDX_W-1:0] cfg_idx,
  input  logic [mtem_pkg::REG_W-1:0]     cfg_wdata
);
  import mtem_pkg::*;

  logic [TAP_COUNT-1:0][REG_W-1:0] tap_r;

  state_t state_r, state_nxt;
  logic   accept, issue_en, out_load, last_issue;

  logic [HIST_DEPTH-1:0][SAMPLE_W-1:0] cell_q;
  logic [HIST_DEPTH-1:0][SAMPLE_W-1:0] cell_tap;

  logic                  run;
  logic [TAP_CNT_W-1:0]  n_act_c;
  logic [FILL_W-1:0]     len_c;
  logic [FILL_W-1:0]     cand;
  logic [FILL_W:0]       held;
  logic                  warm_c;
  logic [FILL_W-1:0]     fill_nxt;

  logic [SAMPLE_W-1:0]   x_r;
  logic                  warm_r;
  logic [FILL_W-1:0]     fill_r;
  logic [TAP_CNT_W-1:0]  n_act_r;
  logic [TAP_IDX_W-1:0]  tap_idx_r;

  logic [REG_W-1:0]      cur_reg;
  logic [HIST_IDX_W-1:0] sel_delay;
  grp_t                  grp_nxt, grp_r;
  logic [WEIGHT_W-1:0]   wa_r;
  logic                  a_vld_r;

  mac_ctl_t              mac_ctl;
  mac_sts_t              mac_sts;
  logic [SAMPLE_W-1:0]   acc_sat;

  logic                  out_valid_r;
  logic [SAMPLE_W-1:0]   out_sample_r;
  logic                  out_warm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_r <= '0;
    end else if (cfg_we) begin
      tap_r[cfg_idx] <= cfg_wdata;
    end
  end

  // history row: cell k holds the sample from k items ago
  genvar k;
  generate
    for (k = 0; k < HIST_DEPTH; k++) begin : g_cell
      if (k == 0) begin : g_head
        mtem_cell u_cell (
          .clk       (clk),
          .rst_n     (rst_n),
          .shift_en  (accept),
          .d_in      (in_sample_in),
          .cell_idx  (HIST_IDX_W'(k)),
          .sel_delay (sel_delay),
          .q         (cell_q[k]),
          .tap_out   (cell_tap[k])
        );
      end else begin : g_body
        mtem_cell u_cell (
          .clk       (clk),
          .rst_n     (rst_n),
          .shift_en  (accept),
          .d_in      (cell_q[k-1]),
          .cell_idx  (HIST_IDX_W'(k)),
          .sel_delay (sel_delay),
          .q         (cell_q[k]),
          .tap_out   (cell_tap[k])
        );
      end
    end
  endgenerate

  // active taps run up to the first zero delay
  always_comb begin
    run     = 1'b1;
    n_act_c = '0;
    len_c   = '0;
    cand    = '0;
    for (int i = 0; i < TAP_COUNT; i++) begin
      run = run && (tap_r[i][DELAY_W-1:0] != '0);
      if (run) begin
        n_act_c = n_act_c + TAP_CNT_W'(1);
        cand    = FILL_W'(tap_delay(tap_r[i])) + FILL_W'(1);
        if (cand > len_c) begin
          len_c = cand;
        end
      end
    end
  end

  assign held     = (FILL_W + 1)'(fill_r) + (FILL_W + 1)'(1);
  assign warm_c   = held < (FILL_W + 1)'(len_c);
  assign fill_nxt = warm_c ? held[FILL_W-1:0] : len_c;

  assign cur_reg    = tap_r[tap_idx_r];
  assign sel_delay  = tap_delay(cur_reg);
  assign last_issue = (TAP_CNT_W'(tap_idx_r) == n_act_r - TAP_CNT_W'(1));

  always_comb begin
    grp_nxt = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      for (int m = 0; m < GROUP_SIZE; m++) begin
        grp_nxt[g] = grp_nxt[g] | cell_tap[g * GROUP_SIZE + m];
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (warm_c || (n_act_c == '0)) ? ST_DONE : ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (last_issue) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!a_vld_r && !mac_sts.busy) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    issue_en = 1'b0;
    out_load = 1'b0;
    case (state_r)
      ST_IDLE:  in_ready = 1'b1;
      ST_ISSUE: issue_en = 1'b1;
      ST_FLUSH: ;
      ST_DONE:  out_load = !out_valid_r || out_ready;
      default:  ;
    endcase
  end

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      a_vld_r     <= 1'b0;
      tap_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      a_vld_r <= issue_en;
      if (accept) begin
        fill_r    <= fill_nxt;
        tap_idx_r <= '0;
      end else if (issue_en) begin
        tap_idx_r <= tap_idx_r + TAP_IDX_W'(1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_r     <= in_sample_in;
      warm_r  <= warm_c;
      n_act_r <= n_act_c;
    end
    if (issue_en) begin
      grp_r <= grp_nxt;
      wa_r  <= tap_weight(cur_reg);
    end
    if (out_load) begin
      out_sample_r <= warm_r ? x_r : acc_sat;
      out_warm_r   <= warm_r;
    end
  end

  assign mac_ctl.load = accept;
  assign mac_ctl.vld  = a_vld_r;

  mtem_mac u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mac_ctl),
    .dry     (dry_gain(in_sample_in)),
    .weight  (wa_r),
    .grp     (grp_r),
    .acc_sat (acc_sat),
    .sts     (mac_sts)
  );

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_warming_up = out_warm_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r != ST_IDLE)
    else $error("accepted transaction did not start processing");

  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ISSUE |-> TAP_CNT_W'(tap_idx_r) < n_act_r)
    else $error("tap issue ran past the active tap list");

  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE |-> !a_vld_r && !mac_sts.busy)
    else $error("result taken while accumulation still in flight");

  assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(HIST_DEPTH))
    else $error("fill count beyond history depth");

endmodule

// ===== rtl/mtem_cell.sv =====
module mtem_cell (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           shift_en,
  input  logic [mtem_pkg::SAMPLE_W-1:0]   d_in,
  input  logic [mtem_pkg::HIST_IDX_W-1:0] cell_idx,
  input  logic [mtem_pkg::HIST_IDX_W-1:0] sel_delay,
  output logic [mtem_pkg::SAMPLE_W-1:0]   q,
  output logic [mtem_pkg::SAMPLE_W-1:0]   tap_out
);
  import mtem_pkg::*;

  logic [SAMPLE_W-1:0] sample_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_r <= '0;
    end else if (shift_en) begin
      sample_r <= d_in;
    end
  end

  assign q = sample_r;
  // only the cell matching the tap delay drives the read bus
  assign tap_out = (sel_delay == cell_idx) ? sample_r : '0;

endmodule

// ===== rtl/mtem_mac.sv =====
module mtem_mac (
  input  logic                         clk,
  input  logic                         rst_n,
  input  mtem_pkg::mac_ctl_t           ctl,
  input  logic [mtem_pkg::SAMPLE_W-1:0] dry,
  input  logic [mtem_pkg::WEIGHT_W-1:0] weight,
  input  mtem_pkg::grp_t               grp,
  output logic [mtem_pkg::SAMPLE_W-1:0] acc_sat,
  output mtem_pkg::mac_sts_t           sts
);
  import mtem_pkg::*;

  logic [SAMPLE_W-1:0] tap_sample;
  logic [PROD_W-1:0]   prod;
  logic [TERM_W-1:0]   term_r;
  logic                b_vld_r;
  logic [ACC_W-1:0]    acc_r;

  always_comb begin
    tap_sample = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      tap_sample = tap_sample | grp[g];
    end
  end

  assign prod = PROD_W'(weight) * PROD_W'(tap_sample) + ROUND_HALF;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else begin
      b_vld_r <= ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.vld) begin
      term_r <= prod[PROD_W-1:8];
    end
    if (ctl.load) begin
      acc_r <= ACC_W'(dry);
    end else if (b_vld_r) begin
      acc_r <= acc_r + ACC_W'(term_r);
    end
  end

  assign acc_sat  = (acc_r > SAT_MAX) ? SAT_MAX[SAMPLE_W-1:0] : acc_r[SAMPLE_W-1:0];
  assign sts.busy = b_vld_r;

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import mtem_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 1700;

  typedef logic [REG_W-1:0] tap_word_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] level;
    logic                warm;
  } echo_out_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [SAMPLE_W-1:0]  in_sample_in;
  logic                 out_valid;
  logic                 out_ready;
  logic [SAMPLE_W-1:0]  out_sample_out;
  logic                 out_warming_up;
  logic                 cfg_we;
  logic [TAP_IDX_W-1:0] cfg_idx;
  logic [REG_W-1:0]     cfg_wdata;

  // tap settings to load next, and the copy the predictor mixes with
  tap_word_t           tap_plan [TAP_COUNT];
  tap_word_t           tap_live [TAP_COUNT];
  logic [SAMPLE_W-1:0] past_samples [HIST_DEPTH];
  int unsigned         held_count;
  echo_out_t           mix_queue [$];

  bit quiet;
  int errors;
  int sent;
  int checked;
  int warm_results;
  int clipped_results;
  int cycles;

  multi_tap_echo_mixer dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample_in   (in_sample_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample_out (out_sample_out),
    .out_warming_up (out_warming_up),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_wdata      (cfg_wdata)
  );

  always #4 clk = ~clk;

  function automatic echo_out_t mix_sample(input logic [SAMPLE_W-1:0] x);
    int unsigned span;
    int unsigned acc;
    int unsigned dly;
    bit          live;
    echo_out_t   r;
    span = 0;
    live = 1'b1;
    for (int i = 0; i < TAP_COUNT; i++) begin
      live = live && (tap_live[i][DELAY_W-1:0] != '0);
      dly = tap_live[i][DELAY_W-1:0];
      if (dly > HIST_DEPTH - 1) dly = HIST_DEPTH - 1;
      if (live && dly + 1 > span) span = dly + 1;
    end
    for (int k = HIST_DEPTH - 1; k > 0; k--) past_samples[k] = past_samples[k-1];
    past_samples[0] = x;
    if (held_count + 1 < span) begin
      held_count = held_count + 1;
      r.level = x;
      r.warm = 1'b1;
      return r;
    end
    held_count = span;
    // dry path at 0.33, rounded half up
    acc = (32'(x) * 33 + 50) / 100;
    live = 1'b1;
    for (int i = 0; i < TAP_COUNT; i++) begin
      live = live && (tap_live[i][DELAY_W-1:0] != '0);
      dly = tap_live[i][DELAY_W-1:0];
      if (dly > HIST_DEPTH - 1) dly = HIST_DEPTH - 1;
      if (live) begin
        acc += (32'(tap_live[i][REG_W-1:DELAY_W]) * 32'(past_samples[dly]) + 32'd128) >> 8;
      end
    end
    if (acc > 255) begin
      acc = 255;
      clipped_results++;
    end
    r.level = acc[SAMPLE_W-1:0];
    r.warm = 1'b0;
    return r;
  endfunction

  task automatic send_sample(input logic [SAMPLE_W-1:0] s);
    while (!quiet && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample_in <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    mix_queue.push_back(mix_sample(s));
    sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (mix_queue.size() != 0) @(posedge clk);
    // let the tap walk finish before touching the registers
    repeat (TAP_COUNT + 4) @(posedge clk);
  endtask

  task automatic load_taps();
    drain_results();
    for (int i = 0; i < TAP_COUNT; i++) begin
      cfg_we <= 1'b1;
      cfg_idx <= TAP_IDX_W'(i);
      cfg_wdata <= tap_plan[i];
      @(posedge clk);
      tap_live[i] = tap_plan[i];
    end
    cfg_we <= 1'b0;
  endtask

  // tap_0 has delay zero, so the later taps are ignored and only the dry path remains
  task automatic test_dry_path();
    logic [SAMPLE_W-1:0] seq [6] = '{8'd0, 8'd255, 8'd1, 8'd254, 8'd100, 8'd50};
    foreach (tap_plan[i]) tap_plan[i] = '0;
    tap_plan[0] = {WEIGHT_W'(1023), DELAY_W'(0)};
    tap_plan[1] = {WEIGHT_W'(256), DELAY_W'(5)};
    load_taps();
    foreach (seq[i]) send_sample(seq[i]);
  endtask

  // one tap at unity weight, junk after the terminating tap
  task automatic test_single_echo();
    logic [SAMPLE_W-1:0] seq [5] = '{8'd200, 8'd255, 8'd255, 8'd0, 8'd7};
    foreach (tap_plan[i]) tap_plan[i] = '0;
    tap_plan[0] = {WEIGHT_W'(256), DELAY_W'(1)};
    tap_plan[2] = {WEIGHT_W'(1023), DELAY_W'(9)};
    load_taps();
    foreach (seq[i]) send_sample(seq[i]);
  endtask

  // all taps at full weight: span grows so the block warms up again, then saturates
  task automatic test_full_bank();
    logic [SAMPLE_W-1:0] seq [8] = '{8'd255, 8'd0, 8'd128, 8'd255, 8'd255, 8'd1, 8'd255, 8'd255};
    foreach (tap_plan[i]) tap_plan[i] = {WEIGHT_W'(1023), DELAY_W'(i + 1)};
    load_taps();
    foreach (seq[i]) send_sample(seq[i]);
  endtask

  // span shrinks, so the held count is clipped and mixing resumes at once
  task automatic test_span_shrink();
    logic [SAMPLE_W-1:0] seq [4] = '{8'd3, 8'd2, 8'd255, 8'd129};
    foreach (tap_plan[i]) tap_plan[i] = '0;
    tap_plan[0] = {WEIGHT_W'(512), DELAY_W'(2)};
    tap_plan[1] = {WEIGHT_W'(1), DELAY_W'(3)};
    tap_plan[3] = {WEIGHT_W'(700), DELAY_W'(64)};
    load_taps();
    foreach (seq[i]) send_sample(seq[i]);
  endtask

  task automatic test_random_phases();
    int issued;
    int phase;
    int run_len;
    int taps;
    int pick;
    logic [DELAY_W-1:0]  dly;
    logic [WEIGHT_W-1:0] wt;
    logic [SAMPLE_W-1:0] s;
    issued = 0;
    phase = 0;
    while (issued < RANDOM_ITEMS) begin
      if (phase == 0) begin
        // deepest history at the largest weight
        foreach (tap_plan[i]) tap_plan[i] = {WEIGHT_W'(1023), DELAY_W'(127)};
        run_len = 200;
      end else begin
        taps = ($urandom_range(3) == 0) ? $urandom_range(TAP_COUNT) : $urandom_range(1, 4);
        for (int i = 0; i < TAP_COUNT; i++) begin
          pick = $urandom_range(9);
          dly = (pick < 7) ? DELAY_W'($urandom_range(1, 15)) :
                (pick < 9) ? DELAY_W'($urandom_range(16, 126)) : DELAY_W'(127);
          pick = $urandom_range(9);
          wt = (pick == 0) ? '0 : (pick == 1) ? '1 : WEIGHT_W'($urandom_range(1023));
          tap_plan[i] = {wt, dly};
        end
        if (taps < TAP_COUNT) tap_plan[taps][DELAY_W-1:0] = '0;
        run_len = $urandom_range(80, 200);
      end
      load_taps();
      quiet = (phase == 2);
      for (int n = 0; n < run_len; n++) begin
        pick = $urandom_range(19);
        s = (pick == 0) ? '0 : (pick == 1) ? '1 :
            (pick == 2) ? SAMPLE_W'($urandom_range(3)) : SAMPLE_W'($urandom_range(255));
        send_sample(s);
      end
      quiet = 1'b0;
      issued += run_len;
      phase++;
    end
  endtask

  always @(posedge clk) begin
    echo_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (mix_queue.size() == 0) begin
        $error("unexpected result: sample_out %0d warming_up %0b",
               out_sample_out, out_warming_up);
        errors++;
      end else begin
        want = mix_queue.pop_front();
        checked++;
        if (want.warm) warm_results++;
        if (out_sample_out !== want.level) begin
          $error("sample_out: expected %0d, got %0d", want.level, out_sample_out);
          errors++;
        end
        if (out_warming_up !== want.warm) begin
          $error("warming_up: expected %0b, got %0b", want.warm, out_warming_up);
          errors++;
        end
      end
    end
    out_ready <= quiet || ($urandom_range(99) >= 15);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_sample_in = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    foreach (tap_live[i]) tap_live[i] = '0;
    foreach (past_samples[k]) past_samples[k] = '0;
    held_count = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_dry_path();
    test_single_echo();
    test_full_bank();
    test_span_shrink();
    test_random_phases();
    drain_results();

    $display("summary: %0d samples mixed, %0d results compared", sent, checked);
    $display("summary: %0d during warm-up, %0d clipped at full scale",
             warm_results, clipped_results);
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/mtem_pkg.sv
rtl/mtem_cell.sv
rtl/mtem_mac.sv
rtl/multi_tap_echo_mixer.sv
verif/tb.sv
